### hw/rtl/mck_pkg.sv
// Shared types, constants and lookup functions of the Morse keyer.
// Used by mck_ctrl, mck_dp and morse_code_keyer_unit; no dependencies.
package mck_pkg;

  localparam int unsigned WpmW    = 6;   // keying speed register
  localparam int unsigned DotW    = 11;  // dot unit in ms, 30..1200
  localparam int unsigned DurW    = 14;  // segment duration in ms
  localparam int unsigned PatW    = 6;   // most elements in one code
  localparam int unsigned LenW    = 3;
  localparam int unsigned CharW   = 8;
  localparam int unsigned InDataW  = 16; // char_code, next_is_symbol, pad
  localparam int unsigned OutDataW = 16; // key_on, duration_ms, pad

  localparam logic [WpmW-1:0] WpmMin   = 6'd1;
  localparam logic [WpmW-1:0] WpmMax   = 6'd40;
  localparam logic [DotW-1:0] DotReset = 11'd60;  // 1200 / 20

  localparam logic [CharW-1:0] CharSpace = 8'h20;

  // Dot unit per speed: 1200 / wpm, rounded down. Entry 0 is never used.
  localparam logic [DotW-1:0] DOT_TAB [0:40] = '{
    11'd1200, 11'd1200, 11'd600, 11'd400, 11'd300, 11'd240, 11'd200,
    11'd171,  11'd150,  11'd133, 11'd120, 11'd109, 11'd100, 11'd92,
    11'd85,   11'd80,   11'd75,  11'd70,  11'd66,  11'd63,  11'd60,
    11'd57,   11'd54,   11'd52,  11'd50,  11'd48,  11'd46,  11'd44,
    11'd42,   11'd41,   11'd40,  11'd38,  11'd37,  11'd36,  11'd35,
    11'd34,   11'd33,   11'd32,  11'd31,  11'd30,  11'd30
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_TONE,
    S_GAP,
    S_TAIL,
    S_SPACE
  } state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_TONE,
    EMIT_GAP,
    EMIT_TAIL,
    EMIT_SPACE
  } emit_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CODE,
    KIND_SPACE
  } kind_t;

  // Code entry: element 0 sits in pat[PatW-1], a set bit is a dash.
  typedef struct packed {
    logic            valid;
    logic [LenW-1:0] len;
    logic [PatW-1:0] pat;
  } code_t;

  typedef struct packed {
    logic  load;     // capture the offered character
    emit_t emit;     // segment to put into the output register
    logic  advance;  // step to the next element
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;       // class of the offered character
    logic  out_free;   // output register can take a segment this cycle
    logic  elem_final; // current element is the last of the code
    logic  next_sym;   // a three-dot gap closes the character
  } dp_stat_t;

  function automatic logic [WpmW-1:0] wpm_sat(input logic [WpmW-1:0] v);
    logic [WpmW-1:0] r;
    r = v;
    if (v < WpmMin) r = WpmMin;
    if (v > WpmMax) r = WpmMax;
    return r;
  endfunction

  function automatic code_t mk(input logic [LenW-1:0] len, input logic [PatW-1:0] pat);
    code_t c;
    c.valid = 1'b1;
    c.len   = len;
    c.pat   = pat;
    return c;
  endfunction

  function automatic code_t code_lookup(input logic [CharW-1:0] ch);
    logic [CharW-1:0] c;
    code_t            r;
    c = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) c = ch - 8'h20;  // fold lower case
    unique case (c)
      8'h41: r = mk(3'd2, 6'b010000);  // A .-
      8'h42: r = mk(3'd4, 6'b100000);  // B -...
      8'h43: r = mk(3'd4, 6'b101000);  // C -.-.
      8'h44: r = mk(3'd3, 6'b100000);  // D -..
      8'h45: r = mk(3'd1, 6'b000000);  // E .
      8'h46: r = mk(3'd4, 6'b001000);  // F ..-.
      8'h47: r = mk(3'd3, 6'b110000);  // G --.
      8'h48: r = mk(3'd4, 6'b000000);  // H ....
      8'h49: r = mk(3'd2, 6'b000000);  // I ..
      8'h4A: r = mk(3'd4, 6'b011100);  // J .---
      8'h4B: r = mk(3'd3, 6'b101000);  // K -.-
      8'h4C: r = mk(3'd4, 6'b010000);  // L .-..
      8'h4D: r = mk(3'd2, 6'b110000);  // M --
      8'h4E: r = mk(3'd2, 6'b100000);  // N -.
      8'h4F: r = mk(3'd3, 6'b111000);  // O ---
      8'h50: r = mk(3'd4, 6'b011000);  // P .--.
      8'h51: r = mk(3'd4, 6'b110100);  // Q --.-
      8'h52: r = mk(3'd3, 6'b010000);  // R .-.
      8'h53: r = mk(3'd3, 6'b000000);  // S ...
      8'h54: r = mk(3'd1, 6'b100000);  // T -
      8'h55: r = mk(3'd3, 6'b001000);  // U ..-
      8'h56: r = mk(3'd4, 6'b000100);  // V ...-
      8'h57: r = mk(3'd3, 6'b011000);  // W .--
      8'h58: r = mk(3'd4, 6'b100100);  // X -..-
      8'h59: r = mk(3'd4, 6'b101100);  // Y -.--
      8'h5A: r = mk(3'd4, 6'b110000);  // Z --..
      8'h30: r = mk(3'd5, 6'b111110);  // 0
      8'h31: r = mk(3'd5, 6'b011110);  // 1
      8'h32: r = mk(3'd5, 6'b001110);  // 2
      8'h33: r = mk(3'd5, 6'b000110);  // 3
      8'h34: r = mk(3'd5, 6'b000010);  // 4
      8'h35: r = mk(3'd5, 6'b000000);  // 5
      8'h36: r = mk(3'd5, 6'b100000);  // 6
      8'h37: r = mk(3'd5, 6'b110000);  // 7
      8'h38: r = mk(3'd5, 6'b111000);  // 8
      8'h39: r = mk(3'd5, 6'b111100);  // 9
      8'h2E: r = mk(3'd6, 6'b010101);  // . .-.-.-
      8'h2C: r = mk(3'd6, 6'b110011);  // , --..--
      8'h3F: r = mk(3'd6, 6'b001100);  // ? ..--..
      8'h21: r = mk(3'd6, 6'b101011);  // ! -.-.--
      8'h2F: r = mk(3'd5, 6'b100100);  // / -..-.
      8'h28: r = mk(3'd5, 6'b101100);  // ( -.--.
      8'h29: r = mk(3'd6, 6'b101101);  // ) -.--.-
      8'h2D: r = mk(3'd6, 6'b100001);  // - -....-
      8'h3D: r = mk(3'd5, 6'b100010);  // = -...-
      8'h2B: r = mk(3'd5, 6'b010100);  // + .-.-.
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/mck_ctrl.sv
// Sequencer of the Morse keyer: walks tone, gap, closing-gap and word-space segments.
// Depends on mck_pkg; drives mck_dp through dp_cmd_t, reads dp_stat_t.
module mck_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mck_pkg::dp_stat_t stat,
  output mck_pkg::dp_cmd_t  cmd
);
  import mck_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.load    = 1'b0;
    cmd.emit    = EMIT_NONE;
    cmd.advance = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          unique case (stat.kind)
            KIND_CODE:  state_nxt = S_TONE;
            KIND_SPACE: state_nxt = S_SPACE;
            default:    state_nxt = S_IDLE;  // unknown character: drop it
          endcase
        end
      end
      S_TONE: begin
        if (stat.out_free) begin
          cmd.emit = EMIT_TONE;
          if (!stat.elem_final) begin
            state_nxt = S_GAP;
          end else if (stat.next_sym) begin
            state_nxt = S_TAIL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_GAP: begin
        if (stat.out_free) begin
          cmd.emit    = EMIT_GAP;
          cmd.advance = 1'b1;
          state_nxt   = S_TONE;
        end
      end
      S_TAIL: begin
        if (stat.out_free) begin
          cmd.emit  = EMIT_TAIL;
          state_nxt = S_IDLE;
        end
      end
      S_SPACE: begin
        if (stat.out_free) begin
          cmd.emit  = EMIT_SPACE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_gap_to_tone: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GAP && stat.out_free) |=> state_r == S_TONE)
    else $error("element gap not followed by a tone");

  a_close_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_TAIL || state_r == S_SPACE) && stat.out_free) |=> state_r == S_IDLE)
    else $error("closing segment did not end the character");

  a_final_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TONE && stat.out_free && stat.elem_final) |=> state_r != S_GAP)
    else $error("gap issued after final element");

endmodule

### hw/rtl/mck_dp.sv
// Datapath of the Morse keyer: dot unit register, code capture, segment output register.
// Depends on mck_pkg; commanded by mck_ctrl.
module mck_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [mck_pkg::WpmW-1:0]     cfg_data,
  input  logic [mck_pkg::InDataW-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mck_pkg::OutDataW-1:0] out_tdata,
  output logic                         out_tlast,
  input  mck_pkg::dp_cmd_t             cmd,
  output mck_pkg::dp_stat_t            stat
);
  import mck_pkg::*;

  logic [DotW-1:0] dot_r;
  logic [PatW-1:0] pat_r;
  logic [LenW-1:0] rem_r;
  logic            nsym_r;
  logic            out_valid_r;
  logic            key_r;
  logic [DurW-1:0] dur_r;
  logic            last_r;

  code_t           code;
  logic [DurW-1:0] dot1;
  logic [DurW-1:0] dot3;
  logic [DurW-1:0] dot7;
  logic            key_nxt;
  logic [DurW-1:0] dur_nxt;
  logic            last_nxt;

  assign code = code_lookup(in_tdata[CharW-1:0]);

  assign stat.kind = (in_tdata[CharW-1:0] == CharSpace) ? KIND_SPACE :
                     code.valid                         ? KIND_CODE  :
                                                          KIND_NONE;

  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.elem_final = (rem_r == LenW'(1));
  assign stat.next_sym   = nsym_r;

  assign dot1 = DurW'(dot_r);
  assign dot3 = (dot1 << 1) + dot1;
  assign dot7 = (dot1 << 3) - dot1;

  always_comb begin
    key_nxt  = 1'b0;
    dur_nxt  = dot1;
    last_nxt = 1'b0;
    unique case (cmd.emit)
      EMIT_TONE: begin
        key_nxt  = 1'b1;
        dur_nxt  = pat_r[PatW-1] ? dot3 : dot1;
        last_nxt = stat.elem_final && !nsym_r;
      end
      EMIT_TAIL: begin
        dur_nxt  = dot3;
        last_nxt = 1'b1;
      end
      EMIT_SPACE: begin
        dur_nxt  = dot7;
        last_nxt = 1'b1;
      end
      default: begin
        dur_nxt = dot1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r       <= DotReset;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        dot_r <= DOT_TAB[wpm_sat(cfg_data)];
      end
      if (cmd.emit != EMIT_NONE) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pat_r  <= code.pat;
      rem_r  <= code.len;
      nsym_r <= in_tdata[CharW];
    end else if (cmd.advance) begin
      pat_r <= pat_r << 1;
      rem_r <= rem_r - LenW'(1);
    end
    if (cmd.emit != EMIT_NONE) begin
      key_r  <= key_nxt;
      dur_r  <= dur_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-DurW-1){1'b0}}, dur_r, key_r};
  assign out_tlast  = last_r;

  a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dot_r >= DotW'(30)) && (dot_r <= DotW'(1200)))
    else $error("dot unit out of range");

  a_tone_has_elem: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit == EMIT_TONE || cmd.emit == EMIT_GAP) |-> rem_r != '0)
    else $error("element issued with no element left");

  a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit != EMIT_NONE) |-> stat.out_free)
    else $error("segment issued over a waiting beat");

endmodule

### hw/rtl/morse_code_keyer_unit.sv
// Morse keyer top level: one text character in, its key segments out.
// A character is taken in idle; its first segment goes into the output register once that is free.
// The mck_ctrl sequencer issues one segment per cycle while the output register drains;
//   a new character is taken only once the last one is issued; unknown characters give none.
// Reset: rst_n synchronous, active low; speed returns to 20 wpm, no beat pending.
// Depends on mck_pkg, mck_ctrl and mck_dp.
module morse_code_keyer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // speed register write: words_per_minute, saturated to 1..40
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mck_pkg::WpmW-1:0]     cfg_data,
  // text input
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [mck_pkg::InDataW-1:0]  in_tdata,   // [7:0] char_code, [8] next_is_symbol
  // key segments
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mck_pkg::OutDataW-1:0] out_tdata,  // [0] key_on, [14:1] duration_ms
  output logic                         out_tlast   // last segment of the character
);
  import mck_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The speed register takes a write on any cycle; the user must write only while idle, unenforced.
  assign cfg_ready = 1'b1;

  // Sequencer: accept a character in idle, then issue one segment per free output
  // slot: tones with gaps between, the closing three-dot gap if asked, or a word space.
  mck_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: hold the dot unit, the code being sent and the output beat.
  mck_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

### bench/tb.sv
// Self-checking bench for morse_code_keyer_unit: directed characters, then random text
// at several keying speeds. An in-bench keyer model predicts the segments of untyped rows.
// Depends on mck_pkg and the keyer RTL.
module tb;
  import mck_pkg::*;

  // One key segment as it leaves the block.
  typedef struct packed {
    logic        key;
    logic [13:0] dur;
    logic        last;
  } seg_t;

  typedef enum logic [1:0] {
    ROW_CHAR,   // character, segments from the keyer model
    ROW_TYPED,  // character, segments typed into the row
    ROW_SPEED   // speed register write, value in val
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] val;
    logic       nsym;
    logic [1:0] cnt;
    seg_t       s0;
    seg_t       s1;
  } stim_row_t;

  localparam int HoldCycles   = 150;
  localparam int SettleCycles = 16;
  localparam int NumPhases    = 7;
  localparam int PhaseItems   = 28;

  // Typed rows hold at reset speed (dot 60 ms) or right after a speed extreme.
  localparam stim_row_t Directed [28] = '{
    '{ROW_TYPED, " ",   1'b0, 2'd1, '{1'b0, 14'd420, 1'b1}, '0},
    '{ROW_TYPED, "E",   1'b0, 2'd1, '{1'b1, 14'd60, 1'b1}, '0},
    '{ROW_TYPED, "T",   1'b1, 2'd2, '{1'b1, 14'd180, 1'b0}, '{1'b0, 14'd180, 1'b1}},
    '{ROW_TYPED, 8'hFF, 1'b1, 2'd0, '0, '0},
    '{ROW_TYPED, 8'h00, 1'b0, 2'd0, '0, '0},
    '{ROW_CHAR,  "a",   1'b1, 2'd0, '0, '0},
    '{ROW_CHAR,  "z",   1'b0, 2'd0, '0, '0},
    '{ROW_CHAR,  "Z",   1'b1, 2'd0, '0, '0},
    '{ROW_CHAR,  "0",   1'b1, 2'd0, '0, '0},
    '{ROW_CHAR,  "9",   1'b0, 2'd0, '0, '0},
    '{ROW_CHAR,  ".",   1'b1, 2'd0, '0, '0},
    '{ROW_CHAR,  ",",   1'b0, 2'd0, '0, '0},
    '{ROW_CHAR,  "?",   1'b1, 2'd0, '0, '0},
    '{ROW_CHAR,  "!",   1'b0, 2'd0, '0, '0},
    '{ROW_CHAR,  "/",   1'b1, 2'd0, '0, '0},
    '{ROW_CHAR,  "(",   1'b0, 2'd0, '0, '0},
    '{ROW_CHAR,  ")",   1'b1, 2'd0, '0, '0},
    '{ROW_CHAR,  "-",   1'b0, 2'd0, '0, '0},
    '{ROW_CHAR,  "=",   1'b1, 2'd0, '0, '0},
    '{ROW_CHAR,  "+",   1'b0, 2'd0, '0, '0},
    '{ROW_CHAR,  "@",   1'b1, 2'd0, '0, '0},
    '{ROW_CHAR,  "{",   1'b0, 2'd0, '0, '0},
    '{ROW_SPEED, 8'd0,  1'b0, 2'd0, '0, '0},
    '{ROW_TYPED, " ",   1'b1, 2'd1, '{1'b0, 14'd8400, 1'b1}, '0},
    '{ROW_CHAR,  "0",   1'b1, 2'd0, '0, '0},
    '{ROW_SPEED, 8'd63, 1'b0, 2'd0, '0, '0},
    '{ROW_TYPED, " ",   1'b0, 2'd1, '{1'b0, 14'd210, 1'b1}, '0},
    '{ROW_CHAR,  "?",   1'b1, 2'd0, '0, '0}
  };

  // Speeds of the random phases; every third phase draws its own.
  localparam logic [5:0] PhaseWpm [NumPhases] = '{
    6'd40, 6'd0, 6'd0, 6'd63, 6'd2, 6'd0, 6'd1
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [WpmW-1:0]     cfg_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;   // [7:0] char_code, [8] next_is_symbol
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;  // [0] key_on, [14:1] duration_ms
  logic                out_tlast;

  seg_t        pending_segs [$];   // segments still owed by the block, oldest first
  int unsigned wpm_shadow   = 20;  // speed register as the bench believes it
  logic        no_idle      = 1'b0;
  logic        hold_req     = 1'b0;
  int          errors       = 0;
  int          chars_sent   = 0;
  int          segs_checked = 0;
  int          speed_writes = 0;

  morse_code_keyer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // Dot/dash pattern of a character after case folding; empty when unknown.
  function automatic string morse_pattern(input logic [7:0] ch);
    logic [7:0] c;
    c = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    case (c)
      "A": return ".-";     "B": return "-...";   "C": return "-.-.";
      "D": return "-..";    "E": return ".";      "F": return "..-.";
      "G": return "--.";    "H": return "....";   "I": return "..";
      "J": return ".---";   "K": return "-.-";    "L": return ".-..";
      "M": return "--";     "N": return "-.";     "O": return "---";
      "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
      "S": return "...";    "T": return "-";      "U": return "..-";
      "V": return "...-";   "W": return ".--";    "X": return "-..-";
      "Y": return "-.--";   "Z": return "--..";
      "0": return "-----";  "1": return ".----";  "2": return "..---";
      "3": return "...--";  "4": return "....-";  "5": return ".....";
      "6": return "-....";  "7": return "--...";  "8": return "---..";
      "9": return "----.";
      ".": return ".-.-.-"; ",": return "--..--"; "?": return "..--..";
      "!": return "-.-.--"; "/": return "-..-.";  "(": return "-.--.";
      ")": return "-.--.-"; "-": return "-....-"; "=": return "-...-";
      "+": return ".-.-.";
      default: return "";
    endcase
  endfunction

  // Queue the key segments one character produces at the current speed.
  task automatic predict_segments(input logic [7:0] ch, input logic nsym);
    string       pat;
    int unsigned dot;
    int          n;
    seg_t        s;
    dot = 1200 / wpm_shadow;
    if (ch == CharSpace) begin
      s = '{1'b0, 14'(dot * 7), 1'b1};
      pending_segs.push_back(s);
      return;
    end
    pat = morse_pattern(ch);
    n   = pat.len();
    for (int j = 0; j < n; j++) begin
      s.key  = 1'b1;
      s.dur  = 14'((pat[j] == "-") ? dot * 3 : dot);
      s.last = (j == n - 1) && !nsym;
      pending_segs.push_back(s);
      // one-dot silence between elements
      if (j != n - 1) begin
        s = '{1'b0, 14'(dot), 1'b0};
        pending_segs.push_back(s);
      end
    end
    // three-dot letter gap closes the character when text goes on
    if (n != 0 && nsym) begin
      s = '{1'b0, 14'(dot * 3), 1'b1};
      pending_segs.push_back(s);
    end
  endtask

  function automatic logic [7:0] pick_char();
    string       marks;
    int unsigned sel;
    marks = ".,?!/()-=+";
    sel   = $urandom_range(0, 99);
    if (sel < 25) return 8'("A" + $urandom_range(0, 25));
    if (sel < 45) return 8'("a" + $urandom_range(0, 25));
    if (sel < 60) return 8'("0" + $urandom_range(0, 9));
    if (sel < 72) return marks[$urandom_range(0, 9)];
    if (sel < 85) return CharSpace;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one character and return at the edge where its beat is taken.
  task automatic offer_char(input logic [7:0] ch, input logic nsym);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, nsym, ch};
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  // Drop valid, wait for every owed segment, then let the sequencer go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_speed(input logic [5:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    wpm_shadow = (v < 6'd1) ? 1 : (v > 6'd40) ? 40 : v;
    speed_writes++;
  endtask

  task automatic check_segment();
    seg_t e;
    if (pending_segs.size() == 0) begin
      report_mismatch($sformatf("segment %h last %b with none owed", out_tdata, out_tlast));
      return;
    end
    e = pending_segs.pop_front();
    segs_checked++;
    if (out_tdata[0] !== e.key)
      report_mismatch($sformatf("key_on %b, want %b", out_tdata[0], e.key));
    if (out_tdata[14:1] !== e.dur)
      report_mismatch($sformatf("duration %0d, want %0d", out_tdata[14:1], e.dur));
    if (out_tlast !== e.last)
      report_mismatch($sformatf("last %b, want %b", out_tlast, e.last));
  endtask

  // Segment receiver: random stalls, one long hold on request, check each beat.
  initial begin : seg_sink
    int w;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        w = no_idle ? 0 : $urandom_range(0, 9);
        if (w != 0) begin
          out_tready <= 1'b0;
          repeat (w) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_segment();
    end
  end

  initial begin : stimulus
    stim_row_t  r;
    logic [7:0] text [PhaseItems];
    logic       nsym;
    logic [5:0] speed;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset speed first, then both speed extremes.
    for (int i = 0; i < $size(Directed); i++) begin
      r = Directed[i];
      if (r.kind == ROW_SPEED) begin
        settle();
        write_speed(r.val[5:0]);
      end else begin
        offer_char(r.val, r.nsym);
        if (r.kind == ROW_TYPED) begin
          if (r.cnt > 0) pending_segs.push_back(r.s0);
          if (r.cnt > 1) pending_segs.push_back(r.s1);
        end else begin
          predict_segments(r.val, r.nsym);
        end
      end
    end

    // Random text: mostly well-formed words, with the letter-gap flag
    // occasionally flipped to break the sequence.
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      speed = (p % 3 == 2) ? 6'($urandom_range(0, 63)) : PhaseWpm[p];
      write_speed(speed);
      no_idle = (p == 2);
      foreach (text[i]) text[i] = pick_char();
      for (int i = 0; i < PhaseItems; i++) begin
        nsym = (i + 1 < PhaseItems) && (text[i + 1] != CharSpace);
        if ($urandom_range(0, 9) == 0) nsym = ~nsym;
        // stall the receiver while characters keep coming
        if (p == 0 && i == 6) hold_req = 1'b1;
        // hold the sender until the block has drained
        if (p == 3 && i == 16) settle();
        offer_char(text[i], nsym);
        predict_segments(text[i], nsym);
      end
    end

    settle();
    $display("%0d characters sent at %0d speed settings, %0d segments checked",
             chars_sent, speed_writes, segs_checked);
    $display("included a %0d-cycle receiver hold and stall-free stretches", HoldCycles);
    if (errors == 0) begin
      $display("PASS morse_code_keyer_unit");
    end else begin
      $display("FAIL morse_code_keyer_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("FAIL morse_code_keyer_unit");
    $finish;
  end

endmodule
